// ===== src/fsg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_pkg
// Shared types, codes and sweep plans for the falling sand grid step core.
// ----------------------------------------------------------------------------
package fsg_pkg;

	localparam int MAX_COLS_DEF = 72;
	localparam int MAX_ROWS_DEF = 84;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_FRAME = 2'd2;
	localparam logic [1:0] MODE_CLEAR = 2'd3;

	localparam logic [1:0] KIND_AIR     = 2'd0;
	localparam logic [1:0] KIND_SAND    = 2'd1;
	localparam logic [1:0] KIND_BEDROCK = 2'd2;

	localparam logic [3:0] DIR_NONE = 4'd8;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_RD_DATA,
		ST_SELF_RD,
		ST_SELF_CHK,
		ST_CAND,
		ST_CAND_CHK,
		ST_WR_DST,
		ST_WR_SRC,
		ST_NEXT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic sweep_init;
		logic user_wr;
		logic user_rd;
		logic user_cap;
		logic rd_self;
		logic rd_cand;
		logic wr_dst;
		logic wr_src;
		logic k_clr;
		logic k_inc;
		logic adv;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic       item_valid;
		logic       out_free;
		logic [1:0] mode;
		logic       user_inside;
		logic       sweep_go;
		logic       self_sand;
		logic       cand_inside;
		logic       cand_air;
		logic       k_last;
		logic       cell_last;
	} sts_t;

	typedef struct packed {
		logic              by_row;
		logic              outer_up;
		logic signed [1:0] dc0, dc1, dc2;
		logic signed [1:0] dr0, dr1, dr2;
	} plan_t;

	function automatic plan_t dir_plan(input logic [2:0] dir);
		plan_t p;
		unique case (dir)
			3'd2:    p = '{1'b0, 1'b0,  2'sd1,  2'sd1,  2'sd1,  2'sd0, -2'sd1,  2'sd1};
			3'd3:    p = '{1'b1, 1'b0,  2'sd1,  2'sd1,  2'sd0,  2'sd1,  2'sd0,  2'sd1};
			3'd4:    p = '{1'b1, 1'b0,  2'sd0, -2'sd1,  2'sd1,  2'sd1,  2'sd1,  2'sd1};
			3'd5:    p = '{1'b1, 1'b0, -2'sd1, -2'sd1,  2'sd0,  2'sd1,  2'sd0,  2'sd1};
			3'd6:    p = '{1'b0, 1'b1, -2'sd1, -2'sd1, -2'sd1,  2'sd0, -2'sd1,  2'sd1};
			default: p = '{1'b1, 1'b1,  2'sd0, -2'sd1,  2'sd1, -2'sd1, -2'sd1, -2'sd1};
		endcase
		return p;
	endfunction

endpackage

// ===== src/fsg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_item_if / fsg_result_if / fsg_cfg_if
// Valid/ready channels of the falling sand grid step core.
// ----------------------------------------------------------------------------
interface fsg_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [6:0] cell_col;
	logic [6:0] cell_row;
	logic [1:0] cell_kind_in;
	logic [3:0] direction;
	modport source (output valid, mode, cell_col, cell_row, cell_kind_in, direction,
		input ready);
	modport sink (input valid, mode, cell_col, cell_row, cell_kind_in, direction,
		output ready);
endinterface

interface fsg_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] cell_kind_out;
	logic       parity_out;
	modport source (output valid, cell_kind_out, parity_out, input ready);
	modport sink (input valid, cell_kind_out, parity_out, output ready);
endinterface

interface fsg_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [6:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/falling_sand_grid_step_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step_core
// Falling sand grid: cell write/read and in-place gravity frames.
// ----------------------------------------------------------------------------
// Usage:
//   item   - one beat per command: write cell, read cell, run frame, clear
//            parity. cell_col/cell_row/cell_kind_in/direction as needed.
//   result - one beat per item: cell_kind_out (read kind, bedrock outside
//            the active grid, else air) and parity_out after the item.
//   cfg    - index 0 sets cols_in_use, index 1 rows_in_use; always ready.
//            Write only while the core is idle.
// Steps: write and clear go from dispatch to done, then raise the result;
//   read adds a data capture step. A frame reads and checks each active
//   cell; a sand cell tries up to three candidates and moves into the first
//   air one. The single-port grid memory takes one read or write per cycle.
// One item is in work at a time. The result register parts both sides: a
// new item is taken as the pending result is taken in the same cycle.
// Reset clears parity and handshakes, sets the sizes to 72 x 84; the
// grid memory holds whatever it held and must be written before it is read.
// A stalled receiver holds the result beat and blocks new items.
// ----------------------------------------------------------------------------
module falling_sand_grid_step_core #(
	parameter int MAX_COLS = fsg_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = fsg_pkg::MAX_ROWS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fsg_item_if.sink     item,
	fsg_result_if.source result,
	fsg_cfg_if.sink      cfg
);
	import fsg_pkg::*;

	cmd_t cmd;
	sts_t st;
	logic in_ready;

	// Configuration writes never stall.
	assign cfg.ready = 1'b1;
	assign item.ready = in_ready;

	fsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.st       (st),
		.cmd      (cmd),
		.in_ready (in_ready)
	);

	fsg_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.item_valid    (item.valid),
		.mode          (item.mode),
		.cell_col      (item.cell_col),
		.cell_row      (item.cell_row),
		.cell_kind_in  (item.cell_kind_in),
		.direction     (item.direction),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.res_valid     (result.valid),
		.res_ready     (result.ready),
		.cell_kind_out (result.cell_kind_out),
		.parity_out    (result.parity_out)
	);

	// A new beat is taken only when the result slot frees up.
	a_in_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |-> (!result.valid || result.ready))
		else $error("item accepted while result slot is occupied");

	// One item at a time: no accept in the cycle after an accept.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second item accepted while one is in work");

	// The result kind is never the unused code.
	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.cell_kind_out != 2'd3)
		else $error("illegal cell kind on result");

endmodule

// ===== src/fsg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_ctrl
// Sequencer for item dispatch and the per-cell settle steps of a frame.
// ----------------------------------------------------------------------------
module fsg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  fsg_pkg::sts_t st,
	output fsg_pkg::cmd_t cmd,
	output logic          in_ready
);
	import fsg_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_ready = (state_q == ST_IDLE) && st.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (st.item_valid && st.out_free) state_d = ST_DISPATCH;
			ST_DISPATCH: begin
				unique case (st.mode)
					MODE_READ:  state_d = st.user_inside ? ST_RD_DATA : ST_DONE;
					MODE_FRAME: state_d = st.sweep_go ? ST_SELF_RD : ST_DONE;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_RD_DATA:  state_d = ST_DONE;
			ST_SELF_RD:  state_d = ST_SELF_CHK;
			ST_SELF_CHK: state_d = st.self_sand ? ST_CAND : ST_NEXT;
			ST_CAND: begin
				if (st.cand_inside) state_d = ST_CAND_CHK;
				else if (st.k_last) state_d = ST_NEXT;
			end
			ST_CAND_CHK: begin
				if (st.cand_air) state_d = ST_WR_DST;
				else if (st.k_last) state_d = ST_NEXT;
				else state_d = ST_CAND;
			end
			ST_WR_DST:   state_d = ST_WR_SRC;
			ST_WR_SRC:   state_d = ST_NEXT;
			ST_NEXT:     state_d = st.cell_last ? ST_DONE : ST_SELF_RD;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE:     cmd.load = st.item_valid && st.out_free;
			ST_DISPATCH: begin
				cmd.user_wr    = (st.mode == MODE_WRITE);
				cmd.user_rd    = (st.mode == MODE_READ) && st.user_inside;
				cmd.sweep_init = (st.mode == MODE_FRAME) && st.sweep_go;
			end
			ST_RD_DATA:  cmd.user_cap = 1'b1;
			ST_SELF_RD:  cmd.rd_self = 1'b1;
			ST_SELF_CHK: cmd.k_clr = 1'b1;
			ST_CAND: begin
				cmd.rd_cand = st.cand_inside;
				cmd.k_inc   = !st.cand_inside && !st.k_last;
			end
			ST_CAND_CHK: cmd.k_inc = !st.cand_air && !st.k_last;
			ST_WR_DST:   cmd.wr_dst = 1'b1;
			ST_WR_SRC:   cmd.wr_src = 1'b1;
			ST_NEXT:     cmd.adv = !st.cell_last;
			ST_DONE:     cmd.out_load = 1'b1;
			default:     cmd = '0;
		endcase
	end

endmodule

// ===== src/fsg_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsg_dp
// Grid memory, sweep position, candidate address and result register.
// ----------------------------------------------------------------------------
module fsg_dp #(
	parameter int MAX_COLS = fsg_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = fsg_pkg::MAX_ROWS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  fsg_pkg::cmd_t cmd,
	output fsg_pkg::sts_t st,
	input  logic          item_valid,
	input  logic [1:0]    mode,
	input  logic [6:0]    cell_col,
	input  logic [6:0]    cell_row,
	input  logic [1:0]    cell_kind_in,
	input  logic [3:0]    direction,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [6:0]    cfg_data,
	output logic          res_valid,
	input  logic          res_ready,
	output logic [1:0]    cell_kind_out,
	output logic          parity_out
);
	import fsg_pkg::*;

	localparam int MAXD   = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
	localparam int DIM_W  = $clog2(MAXD + 1);
	localparam int SW     = DIM_W + 2;
	localparam int DEPTH  = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CMP_W  = (DIM_W > 7) ? DIM_W : 7;

	logic [6:0] cols_q, rows_q;
	logic [1:0] mode_q, kind_q, result_q, k_q, rdata_q;
	logic [6:0] ucol_q, urow_q;
	logic [3:0] dir_q;
	logic       par_q, res_valid_q;
	logic [DIM_W-1:0] c_q, r_q;
	logic [1:0] mem [DEPTH];

	// Clamp the active size to the grid that is built.
	logic [DIM_W-1:0] act_cols, act_rows, last_col, last_row;
	always_comb begin
		act_cols = (CMP_W'(cols_q) > CMP_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : DIM_W'(cols_q);
		act_rows = (CMP_W'(rows_q) > CMP_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : DIM_W'(rows_q);
		last_col = act_cols - DIM_W'(1);
		last_row = act_rows - DIM_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 7'(MAX_COLS_DEF);
			rows_q <= 7'(MAX_ROWS_DEF);
		end else if (cfg_we) begin
			if (cfg_index == CFG_COLS) cols_q <= cfg_data;
			else rows_q <= cfg_data;
		end
	end

	plan_t plan;
	assign plan = dir_plan(dir_q[2:0]);

	logic signed [1:0] dc, dr;
	always_comb begin
		unique case (k_q)
			2'd0:    begin dc = plan.dc0; dr = plan.dr0; end
			2'd1:    begin dc = plan.dc1; dr = plan.dr1; end
			default: begin dc = plan.dc2; dr = plan.dr2; end
		endcase
	end

	logic signed [SW-1:0] cc, cr;
	logic cand_inside;
	always_comb begin
		cc = $signed({2'b00, c_q}) + SW'(dc);
		cr = $signed({2'b00, r_q}) + SW'(dr);
		cand_inside = (cc >= 0) && (cr >= 0) &&
			(cc < $signed({2'b00, act_cols})) && (cr < $signed({2'b00, act_rows}));
	end

	logic user_inside;
	assign user_inside = (CMP_W'(ucol_q) < CMP_W'(act_cols)) &&
		(CMP_W'(urow_q) < CMP_W'(act_rows));

	// Sweep position bookkeeping.
	logic in_up, outer_up, inner_last, outer_last;
	logic [DIM_W-1:0] inner_pos, outer_pos, inner_end, outer_end;
	always_comb begin
		in_up     = par_q;
		outer_up  = plan.outer_up;
		inner_pos = plan.by_row ? c_q : r_q;
		outer_pos = plan.by_row ? r_q : c_q;
		inner_end = plan.by_row ? last_col : last_row;
		outer_end = plan.by_row ? last_row : last_col;
		inner_last = in_up ? (inner_pos == inner_end) : (inner_pos == '0);
		outer_last = outer_up ? (outer_pos == outer_end) : (outer_pos == '0);
	end

	// Memory address: one multiply after the coordinate select.
	logic [DIM_W-1:0] ac;
	logic [DIM_W-1:0] ar;
	logic [ADDR_W-1:0] addr;
	logic [1:0] wdata;
	logic we, re;
	always_comb begin
		if (cmd.rd_cand || cmd.wr_dst) begin
			ac = DIM_W'(cc);
			ar = DIM_W'(cr);
		end else if (cmd.user_rd || cmd.user_wr) begin
			ac = DIM_W'(ucol_q);
			ar = DIM_W'(urow_q);
		end else begin
			ac = c_q;
			ar = r_q;
		end
		addr = ADDR_W'(int'(ar) * MAX_COLS + int'(ac));
		we = cmd.wr_dst || cmd.wr_src ||
			(cmd.user_wr && user_inside && (kind_q != 2'd3));
		re = cmd.rd_self || cmd.rd_cand || cmd.user_rd;
		priority if (cmd.wr_dst) wdata = KIND_SAND;
		else if (cmd.wr_src) wdata = KIND_AIR;
		else wdata = kind_q;
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		if (re) rdata_q <= mem[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			ucol_q <= cell_col;
			urow_q <= cell_row;
			kind_q <= cell_kind_in;
			dir_q  <= direction;
		end
		if (cmd.k_clr) k_q <= 2'd0;
		else if (cmd.k_inc) k_q <= k_q + 2'd1;
	end

	// Start the sweep at the corner set by direction and parity.
	logic [DIM_W-1:0] in_start, out_start;
	always_comb begin
		in_start  = in_up ? '0 : inner_end;
		out_start = outer_up ? '0 : outer_end;
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep_init) begin
			if (plan.by_row) begin
				c_q <= in_start;
				r_q <= out_start;
			end else begin
				r_q <= in_start;
				c_q <= out_start;
			end
		end else if (cmd.adv) begin
			if (plan.by_row) begin
				if (inner_last) begin
					c_q <= in_start;
					r_q <= outer_up ? r_q + DIM_W'(1) : r_q - DIM_W'(1);
				end else c_q <= in_up ? c_q + DIM_W'(1) : c_q - DIM_W'(1);
			end else begin
				if (inner_last) begin
					r_q <= in_start;
					c_q <= outer_up ? c_q + DIM_W'(1) : c_q - DIM_W'(1);
				end else r_q <= in_up ? r_q + DIM_W'(1) : r_q - DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			par_q       <= 1'b0;
			res_valid_q <= 1'b0;
			result_q    <= KIND_AIR;
		end else begin
			if (cmd.load) result_q <= (mode == MODE_READ) ? KIND_BEDROCK : KIND_AIR;
			else if (cmd.user_cap) result_q <= rdata_q;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
				if (mode_q == MODE_FRAME) par_q <= ~par_q;
				else if (mode_q == MODE_CLEAR) par_q <= 1'b0;
			end else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	assign res_valid     = res_valid_q;
	assign cell_kind_out = result_q;
	assign parity_out    = par_q;

	always_comb begin
		st.item_valid  = item_valid;
		st.out_free    = !res_valid_q || res_ready;
		st.mode        = mode_q;
		st.user_inside = user_inside;
		st.sweep_go    = (dir_q < DIR_NONE) && (act_cols != '0) && (act_rows != '0);
		st.self_sand   = (rdata_q == KIND_SAND);
		st.cand_inside = cand_inside;
		st.cand_air    = (rdata_q == KIND_AIR);
		st.k_last      = (k_q == 2'd2);
		st.cell_last   = inner_last && outer_last;
	end

endmodule

// ===== test/falling_sand_grid_step_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step_checker
// Watches the item, result and config channels of the falling sand core,
// keeps its own grid and parity, predicts each result beat and compares.
// ----------------------------------------------------------------------------
module falling_sand_grid_step_checker #(
	parameter int MAX_COLS = fsg_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = fsg_pkg::MAX_ROWS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	fsg_item_if    item,
	fsg_result_if  result,
	fsg_cfg_if     cfg,
	output int     fail_count,
	output int     pending
);
	import fsg_pkg::*;

	localparam logic [3:0] DIR_RIGHT      = 4'd2;
	localparam logic [3:0] DIR_DOWN_RIGHT = 4'd3;
	localparam logic [3:0] DIR_DOWN       = 4'd4;
	localparam logic [3:0] DIR_DOWN_LEFT  = 4'd5;
	localparam logic [3:0] DIR_LEFT       = 4'd6;

	typedef struct {
		logic [1:0] kind;
		logic       parity;
	} cell_answer_t;

	logic [1:0]   grid_model [MAX_COLS*MAX_ROWS];
	logic         parity_model;
	logic [6:0]   cols_reg, rows_reg;
	cell_answer_t answers_due [$];

	assign pending = answers_due.size();

	initial begin
		fail_count = 0;
		foreach (grid_model[i]) grid_model[i] = KIND_AIR;
	end

	function automatic int live_cols();
		return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
	endfunction

	function automatic int live_rows();
		return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
	endfunction

	function automatic logic [1:0] kind_of(input int c, input int r);
		if (c < 0 || r < 0 || c >= live_cols() || r >= live_rows())
			return KIND_BEDROCK;
		return grid_model[r*MAX_COLS + c];
	endfunction

	function automatic void gravity_frame(input logic [3:0] dir);
		int dc[3], dr[3];
		bit by_row, outer_up, inner_up;
		int outer_n, inner_n, o, x, c, r, nc, nr;
		inner_up = parity_model;
		if (dir < DIR_NONE) begin
			case (dir)
				DIR_RIGHT: begin
					by_row = 0; outer_up = 0; dc = '{1, 1, 1}; dr = '{0, -1, 1};
				end
				DIR_DOWN_RIGHT: begin
					by_row = 1; outer_up = 0; dc = '{1, 1, 0}; dr = '{1, 0, 1};
				end
				DIR_DOWN: begin
					by_row = 1; outer_up = 0; dc = '{0, -1, 1}; dr = '{1, 1, 1};
				end
				DIR_DOWN_LEFT: begin
					by_row = 1; outer_up = 0; dc = '{-1, -1, 0}; dr = '{1, 0, 1};
				end
				DIR_LEFT: begin
					by_row = 0; outer_up = 1; dc = '{-1, -1, -1}; dr = '{0, -1, 1};
				end
				// up and both diagonal ups
				default: begin
					by_row = 1; outer_up = 1; dc = '{0, -1, 1}; dr = '{-1, -1, -1};
				end
			endcase
			outer_n = by_row ? live_rows() : live_cols();
			inner_n = by_row ? live_cols() : live_rows();
			for (int i = 0; i < outer_n; i++) begin
				o = outer_up ? i : outer_n - 1 - i;
				for (int j = 0; j < inner_n; j++) begin
					x = inner_up ? j : inner_n - 1 - j;
					c = by_row ? x : o;
					r = by_row ? o : x;
					if (kind_of(c, r) == KIND_SAND) begin
						for (int k = 0; k < 3; k++) begin
							nc = c + dc[k];
							nr = r + dr[k];
							if (kind_of(nc, nr) == KIND_AIR) begin
								grid_model[nr*MAX_COLS + nc] = KIND_SAND;
								grid_model[r*MAX_COLS + c] = KIND_AIR;
								break;
							end
						end
					end
				end
			end
		end
		parity_model = ~parity_model;
	endfunction

	function automatic cell_answer_t apply_item(input logic [1:0] mode, input int c,
			input int r, input logic [1:0] kind, input logic [3:0] dir);
		cell_answer_t a;
		a.kind = KIND_AIR;
		case (mode)
			MODE_WRITE:
				if (c < live_cols() && r < live_rows() && kind <= KIND_BEDROCK)
					grid_model[r*MAX_COLS + c] = kind;
			MODE_READ:  a.kind = kind_of(c, r);
			MODE_FRAME: gravity_frame(dir);
			default:    parity_model = 1'b0;
		endcase
		a.parity = parity_model;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		cell_answer_t want;
		if (!arst_n) begin
			parity_model = 1'b0;
			cols_reg = 7'd72;
			rows_reg = 7'd84;
			answers_due.delete();
		end else begin
			// retire the result beat first: it never belongs to an item taken now
			if (result.valid && result.ready) begin
				if (answers_due.size() == 0) begin
					$display("%0t: result beat with nothing expected (kind %0d parity %0d)",
						$time, result.cell_kind_out, result.parity_out);
					fail_count++;
				end else begin
					want = answers_due.pop_front();
					if (result.cell_kind_out !== want.kind) begin
						$display("%0t: cell_kind_out expected %0d actual %0d",
							$time, want.kind, result.cell_kind_out);
						fail_count++;
					end
					if (result.parity_out !== want.parity) begin
						$display("%0t: parity_out expected %0d actual %0d",
							$time, want.parity, result.parity_out);
						fail_count++;
					end
				end
			end
			if (item.valid && item.ready)
				answers_due.push_back(apply_item(item.mode, int'(item.cell_col),
					int'(item.cell_row), item.cell_kind_in, item.direction));
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == CFG_COLS) cols_reg = cfg.data;
				else rows_reg = cfg.data;
			end
		end
	end

endmodule

// ===== test/falling_sand_grid_step_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// falling_sand_grid_step_core_tb
// Fills the corner of the grid that the small sizes use, then runs directed
// and random cell writes, reads, gravity frames and parity clears over a range
// of active grid sizes, with bursty item traffic and a stalling result side.
// The checker beside the core predicts and compares every result beat.
// ----------------------------------------------------------------------------
module falling_sand_grid_step_core_tb;
	import fsg_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count;
	int   burst_left;
	int   stall_mode;

	fsg_item_if   item_ch ();
	fsg_result_if result_ch ();
	fsg_cfg_if    cfg_ch ();

	falling_sand_grid_step_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	falling_sand_grid_step_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// watchdog: end the run if the core stops answering
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// result side: switch between three stall patterns, one of them stall-free
	always @(negedge clk) begin
		if (cycle_count % 64 == 0) stall_mode <= $urandom_range(0, 2);
		case (stall_mode)
			0:       result_ch.ready <= 1'b1;
			1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
			default: result_ch.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// send one item beat; drop valid for a random gap between bursts
	task automatic send_item(input logic [1:0] mode, input logic [6:0] c,
			input logic [6:0] r, input logic [1:0] kind, input logic [3:0] dir);
		@(negedge clk);
		if (burst_left == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		item_ch.valid        <= 1'b1;
		item_ch.mode         <= mode;
		item_ch.cell_col     <= c;
		item_ch.cell_row     <= r;
		item_ch.cell_kind_in <= kind;
		item_ch.direction    <= dir;
		do @(posedge clk); while (!item_ch.ready);
		burst_left--;
	endtask

	// hold off the sender until every expected beat has come back
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic index, input logic [6:0] value);
		drain();
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [6:0] pick_coord(input int span);
		if (span == 0 || $urandom_range(0, 7) == 0) return 7'($urandom_range(0, 127));
		return 7'($urandom_range(0, span - 1));
	endfunction

	// random traffic at one grid size; frames are rationed
	task automatic random_phase(input int cols, input int rows, input int n,
			input int frame_budget);
		int span_c, span_r, pick;
		logic [1:0] mode, kind;
		span_c = (cols > 72) ? 72 : cols;
		span_r = (rows > 84) ? 84 : rows;
		write_reg(CFG_COLS, cols[6:0]);
		write_reg(CFG_ROWS, rows[6:0]);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40)      mode = MODE_WRITE;
			else if (pick < 65) mode = MODE_READ;
			else if (pick < 92) mode = MODE_FRAME;
			else                mode = MODE_CLEAR;
			if (mode == MODE_FRAME) begin
				if (frame_budget == 0) mode = MODE_READ;
				else frame_budget--;
			end
			// mostly sand, so frames have work to do
			kind = ($urandom_range(0, 2) != 0) ? KIND_SAND : 2'($urandom_range(0, 3));
			send_item(mode, pick_coord(span_c), pick_coord(span_r), kind,
				4'($urandom_range(0, 15)));
			if (i == n / 2 && cols == 8) drain();
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		cycle_count    = 0;
		burst_left     = 0;
		stall_mode     = 0;
		item_ch.valid  = 1'b0;
		item_ch.mode   = MODE_WRITE;
		item_ch.cell_col = '0;
		item_ch.cell_row = '0;
		item_ch.cell_kind_in = KIND_AIR;
		item_ch.direction = DIR_NONE;
		result_ch.ready = 1'b0;
		cfg_ch.valid   = 1'b0;
		cfg_ch.index   = CFG_COLS;
		cfg_ch.data    = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the 8 x 6 corner so no read at the small sizes meets an unwritten cell
		for (int r = 0; r < 6; r++)
			for (int c = 0; c < 8; c++)
				send_item(MODE_WRITE, 7'(c), 7'(r), (r == 5) ? KIND_BEDROCK : KIND_AIR,
					DIR_NONE);

		// directed: small grid, every kind, off-grid access, every direction
		write_reg(CFG_COLS, 7'd8);
		write_reg(CFG_ROWS, 7'd6);
		send_item(MODE_WRITE, 7'd3, 7'd2, KIND_SAND, DIR_NONE);
		send_item(MODE_WRITE, 7'd0, 7'd0, KIND_SAND, DIR_NONE);
		send_item(MODE_WRITE, 7'd7, 7'd5, KIND_SAND, DIR_NONE);
		send_item(MODE_WRITE, 7'd4, 7'd3, KIND_BEDROCK, DIR_NONE);
		send_item(MODE_WRITE, 7'd5, 7'd1, 2'd3, DIR_NONE);          // invalid kind
		send_item(MODE_WRITE, 7'd127, 7'd127, KIND_SAND, DIR_NONE); // off grid
		send_item(MODE_READ, 7'd4, 7'd3, KIND_AIR, DIR_NONE);
		send_item(MODE_READ, 7'd5, 7'd1, KIND_AIR, DIR_NONE);
		send_item(MODE_READ, 7'd127, 7'd0, KIND_AIR, DIR_NONE);
		send_item(MODE_READ, 7'd0, 7'd127, KIND_AIR, DIR_NONE);
		for (int d = 0; d <= 8; d++)
			send_item(MODE_FRAME, 7'd0, 7'd0, KIND_AIR, 4'(d));
		send_item(MODE_FRAME, 7'd0, 7'd0, KIND_AIR, 4'd15);
		send_item(MODE_READ, 7'd3, 7'd2, KIND_AIR, DIR_NONE);
		send_item(MODE_CLEAR, 7'd0, 7'd0, KIND_AIR, DIR_NONE);
		send_item(MODE_FRAME, 7'd0, 7'd0, KIND_AIR, 4'd4);

		// directed: oversized setting clamps to the built grid
		write_reg(CFG_COLS, 7'd127);
		write_reg(CFG_ROWS, 7'd127);
		send_item(MODE_WRITE, 7'd71, 7'd83, KIND_SAND, DIR_NONE);
		send_item(MODE_READ, 7'd71, 7'd83, KIND_AIR, DIR_NONE);
		send_item(MODE_WRITE, 7'd72, 7'd83, KIND_SAND, DIR_NONE);
		send_item(MODE_READ, 7'd72, 7'd0, KIND_AIR, DIR_NONE);
		send_item(MODE_READ, 7'd0, 7'd84, KIND_AIR, DIR_NONE);
		send_item(MODE_FRAME, 7'd0, 7'd0, KIND_AIR, DIR_NONE);

		// random: empty grid and small shapes inside the filled corner
		random_phase(0, 5, 4, 2);
		random_phase(1, 1, 6, 3);
		random_phase(5, 4, 10, 4);
		random_phase(8, 2, 8, 4);
		random_phase(3, 6, 8, 4);
		random_phase(6, 0, 4, 2);
		random_phase(7, 6, 8, 4);

		drain();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
